// ===== hdl/fir_interference_canceller_top_macros.svh =====
// assertion helpers shared by the canceller modules
`ifndef FIR_INTERFERENCE_CANCELLER_TOP_MACROS_SVH
`define FIR_INTERFERENCE_CANCELLER_TOP_MACROS_SVH

// same-cycle implication
`define FIC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FIC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/fic_pkg.sv =====
`timescale 1ns / 1ps

package fic_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int IDX_W        = 6;
   localparam int FRAC_W       = 14;
   localparam int TAPS_DEFAULT = 20;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   typedef struct packed {
      logic                       op;
      logic [IDX_W-1:0]           tap_index;
      logic signed [SAMPLE_W-1:0] data;
      logic signed [SAMPLE_W-1:0] rx;
   } fic_item_type;

   typedef struct packed {
      logic         valid;
      fic_item_type item;
   } fic_head_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_FIN
   } fic_state_type;

endpackage

// ===== hdl/fic_ram.sv =====
`timescale 1ns / 1ps

module fic_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 20
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/fic_front.sv =====
`timescale 1ns / 1ps
`include "fir_interference_canceller_top_macros.svh"

module fic_front #(
   parameter int TAPS = fic_pkg::TAPS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic [fic_pkg::IDX_W-1:0]         req_tap_index,
   input  logic signed [fic_pkg::SAMPLE_W-1:0] req_tap_value,
   input  logic signed [fic_pkg::SAMPLE_W-1:0] req_tx_sample,
   input  logic signed [fic_pkg::SAMPLE_W-1:0] req_rx_sample,
   input  logic                              head_pop,
   output fic_pkg::fic_head_type             head
);

   import fic_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_W:0] TAP_LIMIT = (IDX_W + 1)'(TAPS);

   fic_item_type     slot_ff [QUEUE_DEPTH];
   fic_item_type     item_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             keep;
   logic             push;
   logic             pop;

   // out-of-range tap loads are dropped here
   always_comb begin
      keep              = (req_op == OP_SAMPLE) || ({1'b0, req_tap_index} < TAP_LIMIT);
      item_in.op        = req_op;
      item_in.tap_index = req_tap_index;
      item_in.data      = (req_op == OP_LOAD) ? req_tap_value : req_tx_sample;
      item_in.rx        = req_rx_sample;
   end

   assign req_stall  = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign push       = req_valid && !req_stall && keep;
   assign pop        = head_pop && head.valid;
   assign head.valid = (cnt_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

   `FIC_ASSERT_IMP(a_queue_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
   `FIC_ASSERT_NXT(a_queue_grow, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + 1'b1, "queue count lost a transfer")

endmodule

// ===== hdl/fic_back.sv =====
`timescale 1ns / 1ps
`include "fir_interference_canceller_top_macros.svh"

module fic_back #(
   parameter int TAPS = fic_pkg::TAPS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fic_pkg::fic_head_type               head,
   output logic                                head_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [fic_pkg::SAMPLE_W-1:0] rsp_clean_sample,
   output logic                                rsp_saturated
);

   import fic_pkg::*;

   localparam int AW     = $clog2(TAPS);
   localparam int CNT_W  = $clog2(TAPS + 2);
   localparam int FILL_W = $clog2(TAPS + 1);
   localparam int PROD_W = 2 * SAMPLE_W;
   localparam int ACC_W  = PROD_W + $clog2(TAPS);
   localparam int V_W    = ACC_W + 2;
   localparam logic signed [V_W-1:0] ROUND  = V_W'(1) <<< (FRAC_W - 1);
   localparam logic signed [V_W-1:0] SAT_HI = (V_W'(1) <<< (SAMPLE_W - 1)) - V_W'(1);
   localparam logic signed [V_W-1:0] SAT_LO = ~SAT_HI;

   fic_state_type              state_ff, state_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic [TAPS-1:0]            tap_vld_ff, tap_vld_in;
   logic signed [SAMPLE_W-1:0] win_ff [TAPS];
   logic signed [SAMPLE_W-1:0] rx_ff;
   logic signed [SAMPLE_W-1:0] win_rd_ff;
   logic                       tap_vld_rd_ff;
   logic                       mulv_ff;
   logic                       prodv_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic                       out_vld_ff, out_vld_in;
   logic signed [SAMPLE_W-1:0] clean_ff;
   logic                       sat_ff;

   logic                       tap_we;
   logic                       shift_en;
   logic                       issue;
   logic                       out_free;
   logic                       out_load;
   logic                       fill_full_after;
   logic [SAMPLE_W-1:0]        tap_rd;
   logic signed [SAMPLE_W-1:0] tap_eff;
   logic signed [V_W-1:0]      v_sum;
   logic signed [V_W-1:0]      v_sh;
   logic                       sat_hi;
   logic                       sat_lo;
   logic signed [SAMPLE_W-1:0] clean_in;

   fic_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (TAPS)
   ) u_tap_ram (
      .clock   (clock),
      .wr_en   (tap_we),
      .wr_addr (head.item.tap_index[AW-1:0]),
      .wr_data (head.item.data),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (tap_rd)
   );

   assign out_free        = !out_vld_ff || !rsp_stall;
   assign fill_full_after = (fill_ff >= FILL_W'(TAPS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid && (head.item.op == OP_SAMPLE) && fill_full_after) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (cnt_ff == CNT_W'(TAPS + 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      head_pop = 1'b0;
      issue    = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: head_pop = head.valid;
         ST_MAC:  issue    = (cnt_ff < CNT_W'(TAPS));
         ST_FIN:  out_load = out_free;
         default: head_pop = 1'b0;
      endcase
   end

   assign tap_we   = head_pop && (head.item.op == OP_LOAD);
   assign shift_en = head_pop && (head.item.op == OP_SAMPLE);

   always_comb begin
      cnt_in     = (state_ff == ST_MAC) ? cnt_ff + 1'b1 : '0;
      fill_in    = (shift_en && (fill_ff != FILL_W'(TAPS))) ? fill_ff + 1'b1 : fill_ff;
      tap_vld_in = tap_vld_ff;
      if (tap_we) begin
         tap_vld_in[head.item.tap_index[AW-1:0]] = 1'b1;
      end
      out_vld_in = out_load || (out_vld_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         fill_ff    <= '0;
         tap_vld_ff <= '0;
         mulv_ff    <= 1'b0;
         prodv_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         fill_ff    <= fill_in;
         tap_vld_ff <= tap_vld_in;
         mulv_ff    <= issue;
         prodv_ff   <= mulv_ff;
         out_vld_ff <= out_vld_in;
      end
   end

   // window shifts on a sample, rotates once per tap during the mac pass
   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int i = 0; i < TAPS - 1; i++) begin
            win_ff[i] <= win_ff[i + 1];
         end
         win_ff[TAPS-1] <= head.item.data;
         rx_ff          <= head.item.rx;
      end else if (issue) begin
         for (int i = 0; i < TAPS - 1; i++) begin
            win_ff[i] <= win_ff[i + 1];
         end
         win_ff[TAPS-1] <= win_ff[0];
      end
   end

   assign tap_eff = tap_vld_rd_ff ? signed'(tap_rd) : '0;

   always_ff @(posedge clock) begin
      if (issue) begin
         win_rd_ff     <= win_ff[0];
         tap_vld_rd_ff <= tap_vld_ff[cnt_ff[AW-1:0]];
      end
      prod_ff <= tap_eff * win_rd_ff;
      if (shift_en) begin
         acc_ff <= '0;
      end else if (prodv_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   always_comb begin
      v_sum    = (V_W'(rx_ff) <<< FRAC_W) - V_W'(acc_ff) + ROUND;
      v_sh     = v_sum >>> FRAC_W;
      sat_hi   = (v_sh > SAT_HI);
      sat_lo   = (v_sh < SAT_LO);
      clean_in = sat_hi ? SAT_HI[SAMPLE_W-1:0] :
                 sat_lo ? SAT_LO[SAMPLE_W-1:0] : v_sh[SAMPLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         clean_ff <= clean_in;
         sat_ff   <= sat_hi || sat_lo;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_clean_sample = clean_ff;
   assign rsp_saturated    = sat_ff;

   `FIC_ASSERT_IMP(a_mac_cnt_range, clock, reset, state_ff == ST_MAC, cnt_ff <= CNT_W'(TAPS + 1), "mac counter out of range")
   `FIC_ASSERT_IMP(a_fin_drained, clock, reset, state_ff == ST_FIN, !mulv_ff && !prodv_ff, "mac pipeline not drained at finish")
   `FIC_ASSERT_IMP(a_mac_window_full, clock, reset, (state_ff == ST_MAC) && (cnt_ff == '0), fill_ff == FILL_W'(TAPS), "mac pass started on a partial window")

endmodule

// ===== hdl/fir_interference_canceller_top.sv =====
`timescale 1ns / 1ps
// tap load: one transfer per cycle while req_stall is low, no result
// sample: result once the window holds TAPS samples, through queue, mac pass and output register
// samples are handled one at a time by the single shared tap multiplier
// a two-entry queue keeps accepting, until full, while the mac pass runs or a result waits
// synchronous reset clears control, fill count and tap valid bits; taps then read zero

module fir_interference_canceller_top #(
   parameter int TAPS = fic_pkg::TAPS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic [fic_pkg::IDX_W-1:0]           req_tap_index,
   input  logic signed [fic_pkg::SAMPLE_W-1:0] req_tap_value,
   input  logic signed [fic_pkg::SAMPLE_W-1:0] req_tx_sample,
   input  logic signed [fic_pkg::SAMPLE_W-1:0] req_rx_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [fic_pkg::SAMPLE_W-1:0] rsp_clean_sample,
   output logic                                rsp_saturated
);

   import fic_pkg::*;

   fic_head_type head;
   logic         head_pop;

   fic_front #(
      .TAPS (TAPS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_tap_index (req_tap_index),
      .req_tap_value (req_tap_value),
      .req_tx_sample (req_tx_sample),
      .req_rx_sample (req_rx_sample),
      .head_pop      (head_pop),
      .head          (head)
   );

   fic_back #(
      .TAPS (TAPS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .head_pop         (head_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_clean_sample (rsp_clean_sample),
      .rsp_saturated    (rsp_saturated)
   );

endmodule

// ===== dv/fir_interference_canceller_top_tb.sv =====
`timescale 1ns / 1ps

module fir_interference_canceller_top_tb;
   import fic_pkg::*;

   localparam int TAPS = TAPS_DEFAULT;
   localparam int RANDOM_PER_PHASE = 310;
   localparam int LONG_HOLD_CYCLES = 400;

   typedef struct {
      logic signed [SAMPLE_W-1:0] clean;
      logic                       sat;
   } clean_result_type;

   typedef struct {
      logic                       op;
      logic [IDX_W-1:0]           idx;
      logic signed [SAMPLE_W-1:0] coef;
      logic signed [SAMPLE_W-1:0] tx;
      logic signed [SAMPLE_W-1:0] rx;
      bit                         typed;
      logic signed [SAMPLE_W-1:0] clean;
      logic                       sat;
   } stim_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_op = OP_SAMPLE;
   logic [IDX_W-1:0]           req_tap_index = '0;
   logic signed [SAMPLE_W-1:0] req_tap_value = '0;
   logic signed [SAMPLE_W-1:0] req_tx_sample = '0;
   logic signed [SAMPLE_W-1:0] req_rx_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_clean_sample;
   logic                       rsp_saturated;

   // predictor state
   logic signed [SAMPLE_W-1:0] coef_mirror [TAPS];
   logic signed [SAMPLE_W-1:0] tx_history [TAPS];
   int                         samples_seen;

   clean_result_type pending_clean[$];
   stim_row_type     directed_rows[$];

   int  send_idle_pct = 17;
   int  recv_idle_pct = 73;
   bit  long_hold_on = 1'b0;
   event long_hold_ev;

   int error_count = 0;
   int load_count = 0;
   int sample_count = 0;
   int checked_count = 0;
   int clipped_count = 0;

   fir_interference_canceller_top #(
      .TAPS(TAPS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_tap_index    (req_tap_index),
      .req_tap_value    (req_tap_value),
      .req_tx_sample    (req_tx_sample),
      .req_rx_sample    (req_rx_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_clean_sample (rsp_clean_sample),
      .rsp_saturated    (rsp_saturated)
   );

   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // subtract the tap-weighted tx window from rx, round half up, clip
   function automatic bit cancel_predict(input logic op, input logic [IDX_W-1:0] idx,
                                         input logic signed [SAMPLE_W-1:0] coef,
                                         input logic signed [SAMPLE_W-1:0] tx,
                                         input logic signed [SAMPLE_W-1:0] rx,
                                         output clean_result_type res);
      longint acc;
      longint v;
      acc = 0;
      res.clean = '0;
      res.sat = 1'b0;
      if (op == OP_LOAD) begin
         if (idx < TAPS)
            coef_mirror[idx] = coef;
         return 1'b0;
      end
      for (int j = 0; j + 1 < TAPS; j++)
         tx_history[j] = tx_history[j + 1];
      tx_history[TAPS-1] = tx;
      if (samples_seen < TAPS)
         samples_seen++;
      if (samples_seen < TAPS)
         return 1'b0;
      for (int j = 0; j < TAPS; j++)
         acc += longint'(coef_mirror[j]) * longint'(tx_history[j]);
      v = (longint'(rx) * 16384 - acc + 8192) >>> FRAC_W;
      if (v > 32767) begin
         res.clean = 16'sh7fff;
         res.sat = 1'b1;
      end else if (v < -32768) begin
         res.clean = 16'sh8000;
         res.sat = 1'b1;
      end else begin
         res.clean = SAMPLE_W'(v);
      end
      return 1'b1;
   endfunction

   // entered just after a falling edge, returns just after one
   task automatic send_item(input stim_row_type row);
      clean_result_type res;
      bit has_result;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= row.op;
      req_tap_index <= row.idx;
      req_tap_value <= row.coef;
      req_tx_sample <= row.tx;
      req_rx_sample <= row.rx;
      do
         @(posedge clock);
      while (!(req_valid && !req_stall));
      has_result = cancel_predict(row.op, row.idx, row.coef, row.tx, row.rx, res);
      if (row.op == OP_LOAD)
         load_count++;
      else
         sample_count++;
      if (has_result) begin
         if (row.typed) begin
            res.clean = row.clean;
            res.sat = row.sat;
         end
         pending_clean.insert(pending_clean.size(), res);
      end
      @(negedge clock);
   endtask

   task automatic add_row(input logic op, input logic [IDX_W-1:0] idx,
                          input logic signed [SAMPLE_W-1:0] coef,
                          input logic signed [SAMPLE_W-1:0] tx,
                          input logic signed [SAMPLE_W-1:0] rx, input bit typed,
                          input logic signed [SAMPLE_W-1:0] clean, input logic sat);
      stim_row_type row;
      row.op = op;
      row.idx = idx;
      row.coef = coef;
      row.tx = tx;
      row.rx = rx;
      row.typed = typed;
      row.clean = clean;
      row.sat = sat;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   function automatic stim_row_type random_row();
      stim_row_type row;
      row.typed = 1'b0;
      row.clean = '0;
      row.sat = 1'b0;
      row.op = ($urandom_range(99) < 15) ? OP_LOAD : OP_SAMPLE;
      row.idx = ($urandom_range(99) < 80) ? IDX_W'($urandom_range(TAPS - 1))
                                           : IDX_W'($urandom_range(63));
      row.coef = ($urandom_range(99) < 25) ? SAMPLE_W'($urandom)
                                            : SAMPLE_W'(int'($urandom_range(4095)) - 2048);
      row.tx = ($urandom_range(99) < 30) ? SAMPLE_W'($urandom)
                                          : SAMPLE_W'(int'($urandom_range(8191)) - 4096);
      row.rx = SAMPLE_W'($urandom);
      return row;
   endfunction

   // receiver side
   always @(negedge clock) begin
      if (long_hold_on)
         rsp_stall <= 1'b1;
      else
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(long_hold_ev) begin
      @(posedge clock);
      long_hold_on = 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      long_hold_on = 1'b0;
   end

   // result checker
   always @(posedge clock) begin
      clean_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_clean.size() == 0) begin
            $error("unexpected result transfer: clean_sample %0d saturated %0b",
                   rsp_clean_sample, rsp_saturated);
            error_count++;
         end else begin
            exp_res = pending_clean.pop_front();
            checked_count++;
            if (rsp_saturated)
               clipped_count++;
            if (rsp_clean_sample !== exp_res.clean) begin
               $error("clean_sample mismatch: expected %0d actual %0d",
                      exp_res.clean, rsp_clean_sample);
               error_count++;
            end
            if (rsp_saturated !== exp_res.sat) begin
               $error("saturated mismatch: expected %0b actual %0b",
                      exp_res.sat, rsp_saturated);
               error_count++;
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      for (int j = 0; j < TAPS; j++) begin
         coef_mirror[j] = '0;
         tx_history[j] = '0;
      end
      samples_seen = 0;

      // out-of-range loads, window fill, then extremes with zero and -2.0 taps
      add_row(OP_LOAD, IDX_W'(63), 16'sh7fff, -16'sd1, -16'sd1, 1'b0, '0, 1'b0);
      add_row(OP_LOAD, IDX_W'(TAPS), 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, '0, 1'b0);
      for (int k = 0; k < TAPS - 1; k++)
         add_row(OP_SAMPLE, IDX_W'(63), -16'sd1, (k % 2) ? 16'sh8000 : 16'sh7fff,
                 SAMPLE_W'(k * 1111), 1'b0, '0, 1'b0);
      add_row(OP_SAMPLE, '0, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1, 16'sh7fff, 1'b0);
      add_row(OP_SAMPLE, '0, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b1, 16'sh8000, 1'b0);
      add_row(OP_LOAD, IDX_W'(TAPS - 1), 16'sh8000, 16'sh7fff, 16'sh7fff, 1'b0, '0, 1'b0);
      add_row(OP_SAMPLE, '0, '0, 16'sh8000, 16'sh7fff, 1'b1, 16'sh8000, 1'b1);
      add_row(OP_SAMPLE, '0, '0, 16'sh7fff, 16'sh7fff, 1'b1, 16'sh7fff, 1'b1);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i]);

      for (int p = 0; p < 3; p++) begin
         if (p == 1) begin
            send_idle_pct = 73;
            recv_idle_pct = 17;
         end else if (p == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            -> long_hold_ev;
         end
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            row = random_row();
            send_item(row);
         end
      end
      req_valid <= 1'b0;

      while (pending_clean.size() != 0)
         @(posedge clock);
      repeat (TAPS + 8) @(posedge clock);

      $display("sent %0d tap loads and %0d samples under sender, receiver and long stalls",
               load_count, sample_count);
      $display("checked %0d cleaned samples, %0d of them clipped", checked_count, clipped_count);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/fic_pkg.sv
hdl/fic_ram.sv
hdl/fic_front.sv
hdl/fic_back.sv
hdl/fir_interference_canceller_top.sv
dv/fir_interference_canceller_top_tb.sv
